### hdl/range_rule_table_builder_macros.svh
// assertion macros used by the checker
`ifndef RANGE_RULE_TABLE_BUILDER_MACROS_SVH
`define RANGE_RULE_TABLE_BUILDER_MACROS_SVH

// consequent checked in the same cycle
`define RRTB_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the next cycle
`define RRTB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/rrtb_pkg.sv
`default_nettype none

package rrtb_pkg;

   localparam int CHUNKS_DEF    = 4;
   localparam int ITEM_BITS_DEF = 8;
   localparam int FEATURES_DEF  = 4;
   localparam int RULES_DEF     = 16;

   localparam int CODE_W       = 8;
   localparam int OP_W         = 2;
   localparam int KIND_W       = 3;
   localparam int FEAT_W       = 4;
   localparam int VALUE_W      = 32;
   localparam int RCHUNK_W     = 2;
   localparam int RRULE_W      = 4;
   localparam int RITEM_W      = 8;
   localparam int RULES_USED_W = 5;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 5;
   localparam int FEAT_CFG_W  = 3;
   localparam int CAP_CFG_W   = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_FEATURES_IN_USE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RULE_CAPACITY   = 1'b1;

   localparam logic [FEAT_CFG_W-1:0] FEATURES_IN_USE_RST = 3'd4;
   localparam logic [CAP_CFG_W-1:0]  RULE_CAPACITY_RST   = 5'd16;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_READ   = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_GT = 3'd0,
      KIND_GE = 3'd1,
      KIND_LT = 3'd2,
      KIND_LE = 3'd3,
      KIND_EQ = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FILL,
      ST_READ,
      ST_DONE
   } state_type;

   // code of one entry given where the entry sits against the chunk digit
   function automatic logic [CODE_W-1:0] cell_code(
      input kind_type          kind,
      input logic              above,
      input logic              at,
      input logic              below,
      input logic              last,
      input logic [CODE_W-1:0] mid,
      input logic [CODE_W-1:0] acc
   );
      logic [CODE_W-1:0] code;
      code = '0;
      unique case (kind)
         KIND_GT, KIND_GE: begin
            if (above) begin
               code = acc;
            end else if (at && (!last || kind == KIND_GE)) begin
               code = mid;
            end
         end
         KIND_LT, KIND_LE: begin
            if (below) begin
               code = acc;
            end else if (at && (!last || kind == KIND_LE)) begin
               code = mid;
            end
         end
         KIND_EQ: begin
            if (at) begin
               code = acc;
            end
         end
         default: begin
            code = '0;
         end
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

### hdl/rrtb_ram.sv
`default_nettype none

module rrtb_ram
   import rrtb_pkg::*;
#(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/rrtb_code_gen.sv
`default_nettype none

module rrtb_code_gen
   import rrtb_pkg::*;
#(
   parameter int CHUNKS    = CHUNKS_DEF,
   parameter int ITEM_BITS = ITEM_BITS_DEF,
   localparam int VAL_W  = CHUNKS * ITEM_BITS,
   localparam int WORD_W = CHUNKS * CODE_W
) (
   input  wire kind_type             kind,
   input  wire logic [VAL_W-1:0]     value,
   input  wire logic [ITEM_BITS-1:0] item,
   output logic      [WORD_W-1:0]    word
);

   // one code per chunk for the digit position under the fill counter
   for (genvar c = 0; c < CHUNKS; c++) begin : g_chunk
      localparam bit LAST = (c == CHUNKS - 1);
      localparam int SH   = LAST ? 0 : (CHUNKS - 2 - c);
      localparam logic [CODE_W-1:0] MID = LAST ? CODE_W'(1) : CODE_W'(1 << SH);
      localparam logic [CODE_W-1:0] ACC = LAST ? CODE_W'(1) : CODE_W'(2 << SH);

      logic [ITEM_BITS-1:0] digit;

      assign digit = value[(CHUNKS - 1 - c) * ITEM_BITS +: ITEM_BITS];
      assign word[c * CODE_W +: CODE_W] = cell_code(kind, item > digit, item == digit,
                                                    item < digit, LAST, MID, ACC);
   end

endmodule

`default_nettype wire

### hdl/range_rule_table_builder.sv
// Range rule table builder. Each request is one transfer on the req_ channel and yields
// exactly one transfer on the rsp_ channel. An insert writes the rule row for the next free
// rule into a single synchronous memory holding one word per (rule, digit position), with
// the codes of all chunks side by side; a successful insert steps the fill counter one digit
// position per cycle through the memory's write port. A read does one memory read. Only one
// request is worked on at a time, but the next one is taken while an earlier response still
// waits in the output register. Clear is immediate: rows at or above the rule count read as
// zero, and each row remembers the one feature it was built for, so no clearing pass is
// needed after reset or clear.
// csr_ writes must only happen while no request is in flight.
`default_nettype none

module range_rule_table_builder
   import rrtb_pkg::*;
#(
   parameter int CHUNKS    = CHUNKS_DEF,
   parameter int ITEM_BITS = ITEM_BITS_DEF,
   parameter int FEATURES  = FEATURES_DEF,
   parameter int RULES     = RULES_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,

   input  wire logic                    csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_write_data,

   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [OP_W-1:0]         req_operation,
   input  wire logic [KIND_W-1:0]       req_compare_kind,
   input  wire logic [FEAT_W-1:0]       req_feature_sel,
   input  wire logic [VALUE_W-1:0]      req_rule_value,
   input  wire logic [RCHUNK_W-1:0]     req_read_chunk,
   input  wire logic [RRULE_W-1:0]      req_read_rule,
   input  wire logic [RITEM_W-1:0]      req_read_item,

   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic                         rsp_status,
   output logic [CODE_W-1:0]            rsp_entry_code,
   output logic [RULES_USED_W-1:0]      rsp_rules_used
);

   localparam int ITEMS   = 1 << ITEM_BITS;
   localparam int RULE_W  = (RULES > 1) ? $clog2(RULES) : 1;
   localparam int ROWS    = 1 << RULE_W;
   localparam int DEPTH   = ROWS * ITEMS;
   localparam int ADDR_W  = RULE_W + ITEM_BITS;
   localparam int CNT_W   = $clog2(RULES + 1);
   localparam int CHUNK_W = $clog2(CHUNKS);
   localparam int VAL_W   = CHUNKS * ITEM_BITS;
   localparam int WORD_W  = CHUNKS * CODE_W;

   state_type state_ff, state_in;

   logic [FEAT_CFG_W-1:0] features_in_use_ff;
   logic [CAP_CFG_W-1:0]  rule_capacity_ff;
   logic [CNT_W-1:0]      rule_count_ff;
   logic [ITEM_BITS-1:0]  item_cnt_ff;

   op_type                op_ff;
   kind_type              kind_ff;
   logic [FEAT_W-1:0]     feat_ff;
   logic [VAL_W-1:0]      value_ff;
   logic [RCHUNK_W-1:0]   rchunk_ff;
   logic [RRULE_W-1:0]    rrule_ff;
   logic [RITEM_W-1:0]    ritem_ff;

   logic [FEAT_W-1:0]     row_feat_ff [ROWS];

   logic                  status_ff;
   logic [CODE_W-1:0]     entry_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_status_ff;
   logic [CODE_W-1:0]     rsp_entry_code_ff;
   logic [RULES_USED_W-1:0] rsp_rules_used_ff;

   logic                  capture;
   logic                  insert_fail;
   logic                  fill_last;
   logic                  rsp_free;
   logic                  mem_wr_en;
   logic                  mem_rd_en;
   logic                  tag_wr;
   logic                  cnt_clear;
   logic                  cnt_inc;
   logic                  decode_load;
   logic                  entry_load;
   logic                  rsp_load;

   logic [RULE_W-1:0]     row_idx;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ADDR_W-1:0]     rd_addr;
   logic [WORD_W-1:0]     wr_word;
   logic [WORD_W-1:0]     rd_word;

   logic [31:0]           rchunk_ext;
   logic [31:0]           rrule_ext;
   logic [31:0]           ritem_ext;
   logic [31:0]           feat_ext;
   logic [CHUNK_W-1:0]    chunk_idx;
   logic [RULE_W-1:0]     read_row;
   logic                  read_hit;
   logic [CODE_W-1:0]     read_code;

   // request checks
   assign feat_ext    = 32'(feat_ff);
   assign insert_fail = (32'(rule_count_ff) >= 32'(rule_capacity_ff))
                        || (32'(rule_count_ff) >= RULES)
                        || (feat_ext >= 32'(features_in_use_ff))
                        || (feat_ext >= FEATURES)
                        || (kind_ff > KIND_EQ);

   assign fill_last = (item_cnt_ff == ITEM_BITS'(ITEMS - 1));
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            priority if (op_ff == OP_INSERT && !insert_fail) begin
               state_in = ST_FILL;
            end else if (op_ff == OP_READ) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_FILL: begin
            if (fill_last) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // controls
   always_comb begin
      req_ready   = (state_ff == ST_IDLE);
      capture     = req_valid && (state_ff == ST_IDLE);
      decode_load = (state_ff == ST_DECODE);
      mem_rd_en   = (state_ff == ST_DECODE) && (op_ff == OP_READ);
      tag_wr      = (state_ff == ST_DECODE) && (op_ff == OP_INSERT) && !insert_fail;
      cnt_clear   = (state_ff == ST_DECODE) && (op_ff == OP_CLEAR);
      mem_wr_en   = (state_ff == ST_FILL);
      cnt_inc     = (state_ff == ST_FILL) && fill_last;
      entry_load  = (state_ff == ST_READ);
      rsp_load    = (state_ff == ST_DONE) && rsp_free;
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         features_in_use_ff <= FEATURES_IN_USE_RST;
         rule_capacity_ff   <= RULE_CAPACITY_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FEATURES_IN_USE: features_in_use_ff <= csr_write_data[FEAT_CFG_W-1:0];
            CSR_RULE_CAPACITY:   rule_capacity_ff   <= csr_write_data[CAP_CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rule_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cnt_clear) begin
            rule_count_ff <= '0;
         end else if (cnt_inc) begin
            rule_count_ff <= rule_count_ff + CNT_W'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request fields
   always_ff @(posedge clock) begin
      if (capture) begin
         op_ff     <= op_type'(req_operation);
         kind_ff   <= kind_type'(req_compare_kind);
         feat_ff   <= req_feature_sel;
         value_ff  <= VAL_W'(req_rule_value);
         rchunk_ff <= req_read_chunk;
         rrule_ff  <= req_read_rule;
         ritem_ff  <= req_read_item;
      end
   end

   // fill counter and row feature tags
   always_ff @(posedge clock) begin
      if (decode_load) begin
         item_cnt_ff <= '0;
      end else if (mem_wr_en) begin
         item_cnt_ff <= item_cnt_ff + ITEM_BITS'(1);
      end
      if (tag_wr) begin
         row_feat_ff[row_idx] <= feat_ff;
      end
   end

   // result of the current request
   always_ff @(posedge clock) begin
      if (decode_load) begin
         status_ff <= (op_ff == OP_INSERT) && insert_fail;
         entry_ff  <= '0;
      end else if (entry_load) begin
         entry_ff <= read_code;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff     <= status_ff;
         rsp_entry_code_ff <= entry_ff;
         rsp_rules_used_ff <= RULES_USED_W'(rule_count_ff);
      end
   end

   // rule rows
   assign row_idx = rule_count_ff[RULE_W-1:0];
   assign wr_addr = {row_idx, item_cnt_ff};

   rrtb_code_gen #(
      .CHUNKS    (CHUNKS),
      .ITEM_BITS (ITEM_BITS)
   ) u_code_gen (
      .kind  (kind_ff),
      .value (value_ff),
      .item  (item_cnt_ff),
      .word  (wr_word)
   );

   // read path
   assign rchunk_ext = 32'(rchunk_ff);
   assign rrule_ext  = 32'(rrule_ff);
   assign ritem_ext  = 32'(ritem_ff);
   assign chunk_idx  = rchunk_ext[CHUNK_W-1:0];
   assign read_row   = rrule_ext[RULE_W-1:0];
   assign rd_addr    = {read_row, ritem_ext[ITEM_BITS-1:0]};

   assign read_hit = (rchunk_ext < CHUNKS) && (rrule_ext < RULES)
                     && (ritem_ext < ITEMS) && (feat_ext < FEATURES)
                     && (rrule_ext < 32'(rule_count_ff))
                     && (row_feat_ff[read_row] == feat_ff);

   assign read_code = read_hit ? rd_word[chunk_idx * CODE_W +: CODE_W] : '0;

   rrtb_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_code_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_entry_code = rsp_entry_code_ff;
   assign rsp_rules_used = rsp_rules_used_ff;

endmodule

`default_nettype wire

### hdl/rrtb_checker.sv
`default_nettype none
`include "range_rule_table_builder_macros.svh"

module rrtb_checker
   import rrtb_pkg::*;
#(
   parameter int RULES = RULES_DEF
) (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_ready,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic                    rsp_status,
   input wire logic [CODE_W-1:0]       rsp_entry_code,
   input wire logic [RULES_USED_W-1:0] rsp_rules_used
);

   // a stalled response holds
   `RRTB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_entry_code) && $stable(rsp_rules_used), "stalled response changed")

   // one request in flight at a time
   `RRTB_ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")

   // a failed insert returns no entry
   `RRTB_ASSERT_SAME(a_fail_no_entry, clock, reset, rsp_valid && rsp_status, rsp_entry_code == '0, "failed insert with entry code")

   // rule count stays within the table
   `RRTB_ASSERT_SAME(a_count_bound, clock, reset, rsp_valid, 32'(rsp_rules_used) <= RULES, "rule count beyond table")

   // reset leaves the block idle and empty
   `RRTB_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && req_ready, "not idle after reset")

endmodule

bind range_rule_table_builder rrtb_checker #(.RULES(RULES)) u_checker (.*);

`default_nettype wire
